// ===== rtl/core/fpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfs_pkg
// Shared widths, codes and types of the frame pool fifo with statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfs_pkg;

	// parameter defaults
	localparam int DEPTH_DEF       = 64;
	localparam int MARGIN_DEF      = 8;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	// field widths
	localparam int MODE_W   = 2;
	localparam int HANDLE_W = 16;
	localparam int KIND_W   = 3;
	localparam int LAG_W    = 32;
	localparam int OCC_W    = 7;
	localparam int STAT_W   = 32;
	localparam int LEVEL_W  = 7;
	localparam int CFG_DW   = 32;
	localparam int CFG_AW   = 4;
	localparam int REG_IDX_W = 2;

	// item modes
	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PUSH_OK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DISABLED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POPPED   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd5;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_QUEUE_LIMIT    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_STEADY_LEVEL   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_QUEUE_DISABLED = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ADJUST_ENABLE  = 2'd3;

	localparam logic [LEVEL_W-1:0] QUEUE_LIMIT_RST  = 7'd64;
	localparam logic [LEVEL_W-1:0] STEADY_LEVEL_RST = 7'd32;

	typedef struct packed {
		logic [LEVEL_W-1:0] queue_limit;
		logic [LEVEL_W-1:0] steady_level;
		logic               queue_disabled;
		logic               adjust_enable;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic              accept;
		logic              do_tick;
		logic              do_clear;
		logic              push_write;
		logic              count_ovf;
		logic              hold_alloc;
		logic              take;
		logic              emit;
		logic              emit_exec;
		logic [KIND_W-1:0] kind;
		logic              last;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KIND_W-1:0] push_kind;
		logic              rel_push;
		logic              rel_now;
		logic              count_nz;
		logic              out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpfs_if.sv =====
// ----------------------------------------------------------------------------
// fpfs item and result channels
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfs_item_if;
	logic                              valid;
	logic                              ready;
	logic [fpfs_pkg::MODE_W-1:0]       mode;
	logic [fpfs_pkg::HANDLE_W-1:0]     frame_handle;

	modport source (output valid, output mode, output frame_handle, input ready);
	modport sink (input valid, input mode, input frame_handle, output ready);
endinterface

interface fpfs_result_if;
	logic                              valid;
	logic                              ready;
	logic [fpfs_pkg::KIND_W-1:0]       result_kind;
	logic [fpfs_pkg::HANDLE_W-1:0]     out_handle;
	logic [fpfs_pkg::LAG_W-1:0]        frame_lag;
	logic [fpfs_pkg::OCC_W-1:0]        occupancy;
	logic [fpfs_pkg::OCC_W-1:0]        high_water;
	logic [fpfs_pkg::STAT_W-1:0]       overflow_total;
	logic [fpfs_pkg::LAG_W-1:0]        worst_wait;
	logic                              alloc_request;
	logic                              last_of_run;

	modport source (output valid, output result_kind, output out_handle, output frame_lag,
		output occupancy, output high_water, output overflow_total, output worst_wait,
		output alloc_request, output last_of_run, input ready);
	modport sink (input valid, input result_kind, input out_handle, input frame_lag,
		input occupancy, input high_water, input overflow_total, input worst_wait,
		input alloc_request, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpfs_ram.sv =====
// ----------------------------------------------------------------------------
// fpfs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_ram #(
	parameter int WIDTH = fpfs_pkg::HANDLE_BITS_DEF,
	parameter int DEPTH = fpfs_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpfs_regs.sv =====
// ----------------------------------------------------------------------------
// fpfs_regs
// APB configuration registers: queue limit, steady level and control bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fpfs_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [fpfs_pkg::CFG_DW-1:0]   pwdata,
	output logic      [fpfs_pkg::CFG_DW-1:0]   prdata,
	output logic                               pready,
	output fpfs_pkg::cfg_t                     cfg
);

	fpfs_pkg::cfg_t                      cfg_q;
	logic [fpfs_pkg::REG_IDX_W-1:0]      reg_idx;
	logic                                wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[fpfs_pkg::CFG_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_limit    <= fpfs_pkg::QUEUE_LIMIT_RST;
			cfg_q.steady_level   <= fpfs_pkg::STEADY_LEVEL_RST;
			cfg_q.queue_disabled <= 1'b0;
			cfg_q.adjust_enable  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				fpfs_pkg::REG_QUEUE_LIMIT:    cfg_q.queue_limit <= pwdata[fpfs_pkg::LEVEL_W-1:0];
				fpfs_pkg::REG_STEADY_LEVEL:   cfg_q.steady_level <= pwdata[fpfs_pkg::LEVEL_W-1:0];
				fpfs_pkg::REG_QUEUE_DISABLED: cfg_q.queue_disabled <= pwdata[0];
				fpfs_pkg::REG_ADJUST_ENABLE:  cfg_q.adjust_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fpfs_pkg::REG_QUEUE_LIMIT:    prdata = fpfs_pkg::CFG_DW'(cfg_q.queue_limit);
			fpfs_pkg::REG_STEADY_LEVEL:   prdata = fpfs_pkg::CFG_DW'(cfg_q.steady_level);
			fpfs_pkg::REG_QUEUE_DISABLED: prdata = fpfs_pkg::CFG_DW'(cfg_q.queue_disabled);
			fpfs_pkg::REG_ADJUST_ENABLE:  prdata = fpfs_pkg::CFG_DW'(cfg_q.adjust_enable);
			default:                      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpfs_ctl.sv =====
// ----------------------------------------------------------------------------
// fpfs_ctl
// Item sequencer: decides per item which datapath steps run and which
// results are emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_ctl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  fpfs_pkg::dp_status_t      status,
	output fpfs_pkg::ctl_cmd_t        cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_TAKE   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]                    state_q, state_d;
	logic [fpfs_pkg::KIND_W-1:0]   take_kind_q, take_kind_d;
	logic                          more_after_take;

	assign item_ready = (state_q == ST_IDLE);

	// a release ahead of a pop is followed by the pop itself
	assign more_after_take = (take_kind_q == fpfs_pkg::KIND_RELEASE) &&
		(status.mode == fpfs_pkg::MODE_POP);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		take_kind_d = take_kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (status.mode)
					fpfs_pkg::MODE_TICK: begin
						cmd.do_tick = 1'b1;
						state_d     = ST_IDLE;
					end
					fpfs_pkg::MODE_CLEAR: begin
						cmd.do_clear = 1'b1;
						state_d      = ST_IDLE;
					end
					fpfs_pkg::MODE_PUSH: begin
						if (status.out_free) begin
							cmd.emit       = 1'b1;
							cmd.emit_exec  = 1'b1;
							cmd.hold_alloc = 1'b1;
							cmd.kind       = status.push_kind;
							cmd.push_write = (status.push_kind == fpfs_pkg::KIND_PUSH_OK);
							cmd.count_ovf  = (status.push_kind == fpfs_pkg::KIND_OVERFLOW);
							cmd.last       = !status.rel_push;
							if (status.rel_push) begin
								take_kind_d = fpfs_pkg::KIND_RELEASE;
								state_d     = ST_LOAD;
							end else begin
								state_d = ST_IDLE;
							end
						end
					end
					default: begin
						cmd.hold_alloc = 1'b1;
						if (status.rel_now) begin
							take_kind_d = fpfs_pkg::KIND_RELEASE;
							state_d     = ST_LOAD;
						end else if (status.count_nz) begin
							take_kind_d = fpfs_pkg::KIND_POPPED;
							state_d     = ST_LOAD;
						end else if (status.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_exec = 1'b1;
							cmd.kind      = fpfs_pkg::KIND_EMPTY;
							cmd.last      = 1'b1;
							state_d       = ST_IDLE;
						end
					end
				endcase
			end
			ST_LOAD: begin
				// head read is in flight
				state_d = ST_TAKE;
			end
			ST_TAKE: begin
				if (status.out_free) begin
					cmd.take = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = take_kind_q;
					cmd.last = !more_after_take;
					state_d  = more_after_take ? ST_FINISH : ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (status.count_nz) begin
					take_kind_d = fpfs_pkg::KIND_POPPED;
					state_d     = ST_LOAD;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = fpfs_pkg::KIND_EMPTY;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			take_kind_q <= fpfs_pkg::KIND_POPPED;
		end else begin
			state_q     <= state_d;
			take_kind_q <= take_kind_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpfs_dp.sv =====
// ----------------------------------------------------------------------------
// fpfs_dp
// Queue datapath: pointers, occupancy, statistics, time counter, handle and
// stamp stores, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_dp #(
	parameter int DEPTH       = fpfs_pkg::DEPTH_DEF,
	parameter int MARGIN      = fpfs_pkg::MARGIN_DEF,
	parameter int HANDLE_BITS = fpfs_pkg::HANDLE_BITS_DEF,
	parameter int TIME_BITS   = fpfs_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  fpfs_pkg::cfg_t                     cfg,
	input  fpfs_pkg::ctl_cmd_t                 cmd,
	output fpfs_pkg::dp_status_t               status,
	input  wire logic [fpfs_pkg::MODE_W-1:0]   item_mode,
	input  wire logic [fpfs_pkg::HANDLE_W-1:0] item_handle,
	fpfs_result_if.source                      result
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > fpfs_pkg::LEVEL_W) ? CW : fpfs_pkg::LEVEL_W) + 2;

	logic [fpfs_pkg::MODE_W-1:0]   mode_q;
	logic [fpfs_pkg::HANDLE_W-1:0] handle_q;
	logic [AW-1:0]                 head_q, tail_q;
	logic [CW-1:0]                 count_q, count_d;
	logic [CW-1:0]                 peak_q, peak_d;
	logic [fpfs_pkg::STAT_W-1:0]   ovf_q, ovf_d;
	logic [TIME_BITS-1:0]          peak_lag_q, peak_lag_d;
	logic [TIME_BITS-1:0]          time_q;
	logic                          alloc_q;

	logic [HANDLE_BITS-1:0]        handle_kept;
	logic [HANDLE_BITS-1:0]        handle_rd;
	logic [TIME_BITS-1:0]          stamp_rd;
	logic [TIME_BITS-1:0]          lag;

	logic [CMPW-1:0]               cnt_w, cnt1_w, steady_w, marg_w, limit_w;
	logic                          push_ok, alloc_push, alloc_now, exec_alloc;

	logic                          out_valid_q;
	logic [fpfs_pkg::KIND_W-1:0]   kind_q;
	logic [fpfs_pkg::HANDLE_W-1:0] out_handle_q, out_handle_d;
	logic [fpfs_pkg::LAG_W-1:0]    lag_out_q, lag_out_d;
	logic [fpfs_pkg::OCC_W-1:0]    occ_q, hw_q;
	logic [fpfs_pkg::STAT_W-1:0]   ovf_out_q;
	logic [fpfs_pkg::LAG_W-1:0]    worst_q;
	logic                          alloc_out_q, last_q;

	assign handle_kept = HANDLE_BITS'(handle_q);
	assign lag         = time_q - stamp_rd;

	// adjust and limit compares
	assign cnt_w    = CMPW'(count_q);
	assign cnt1_w   = cnt_w + CMPW'(1);
	assign steady_w = CMPW'(cfg.steady_level);
	assign marg_w   = CMPW'(MARGIN);
	assign limit_w  = (CMPW'(cfg.queue_limit) < CMPW'(DEPTH)) ? CMPW'(cfg.queue_limit) :
		CMPW'(DEPTH);

	assign push_ok    = !cfg.queue_disabled && (cnt_w < limit_w);
	assign alloc_push = push_ok && cfg.adjust_enable && (cnt1_w + marg_w < steady_w);
	assign alloc_now  = cfg.adjust_enable && (cnt_w + marg_w < steady_w);
	assign exec_alloc = (mode_q == fpfs_pkg::MODE_PUSH) ? alloc_push : alloc_now;

	always_comb begin
		status.mode      = mode_q;
		status.push_kind = cfg.queue_disabled ? fpfs_pkg::KIND_DISABLED :
			(push_ok ? fpfs_pkg::KIND_PUSH_OK : fpfs_pkg::KIND_OVERFLOW);
		status.rel_push  = push_ok && cfg.adjust_enable && (cnt1_w > steady_w + marg_w);
		status.rel_now   = cfg.adjust_enable && (cnt_w > steady_w + marg_w) && (count_q != '0);
		status.count_nz  = (count_q != '0);
		status.out_free  = !out_valid_q || result.ready;
	end

	// next values of the counters and statistics
	always_comb begin
		count_d    = count_q;
		peak_d     = peak_q;
		ovf_d      = ovf_q;
		peak_lag_d = peak_lag_q;
		if (cmd.push_write) begin
			count_d = count_q + CW'(1);
			if (count_d > peak_q) begin
				peak_d = count_d;
			end
		end
		if (cmd.take) begin
			count_d = count_q - CW'(1);
			if (lag > peak_lag_q) begin
				peak_lag_d = lag;
			end
		end
		if (cmd.count_ovf && (ovf_q != '1)) begin
			ovf_d = ovf_q + fpfs_pkg::STAT_W'(1);
		end
		if (cmd.do_clear) begin
			peak_d     = '0;
			peak_lag_d = '0;
		end
	end

	always_comb begin
		case (cmd.kind) inside
			fpfs_pkg::KIND_PUSH_OK, fpfs_pkg::KIND_OVERFLOW, fpfs_pkg::KIND_DISABLED: begin
				out_handle_d = fpfs_pkg::HANDLE_W'(handle_kept);
				lag_out_d    = '0;
			end
			fpfs_pkg::KIND_POPPED, fpfs_pkg::KIND_RELEASE: begin
				out_handle_d = fpfs_pkg::HANDLE_W'(handle_rd);
				lag_out_d    = fpfs_pkg::LAG_W'(lag);
			end
			default: begin
				out_handle_d = '0;
				lag_out_d    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= fpfs_pkg::MODE_TICK;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			ovf_q       <= '0;
			peak_lag_q  <= '0;
			time_q      <= '0;
			alloc_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				mode_q <= item_mode;
			end
			if (cmd.push_write) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (cmd.take) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (cmd.do_tick && (time_q != '1)) begin
				time_q <= time_q + TIME_BITS'(1);
			end
			if (cmd.hold_alloc) begin
				alloc_q <= exec_alloc;
			end
			count_q    <= count_d;
			peak_q     <= peak_d;
			ovf_q      <= ovf_d;
			peak_lag_q <= peak_lag_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			handle_q <= item_handle;
		end
		if (cmd.emit) begin
			kind_q       <= cmd.kind;
			out_handle_q <= out_handle_d;
			lag_out_q    <= lag_out_d;
			occ_q        <= fpfs_pkg::OCC_W'(count_d);
			hw_q         <= fpfs_pkg::OCC_W'(peak_d);
			ovf_out_q    <= ovf_d;
			worst_q      <= fpfs_pkg::LAG_W'(peak_lag_d);
			alloc_out_q  <= cmd.emit_exec ? exec_alloc : alloc_q;
			last_q       <= cmd.last;
		end
	end

	fpfs_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_handle_ram (
		.clk     (clk),
		.wr_en   (cmd.push_write),
		.wr_addr (tail_q),
		.wr_data (handle_kept),
		.rd_addr (head_q),
		.rd_data (handle_rd)
	);

	fpfs_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (DEPTH)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (cmd.push_write),
		.wr_addr (tail_q),
		.wr_data (time_q),
		.rd_addr (head_q),
		.rd_data (stamp_rd)
	);

	assign result.valid          = out_valid_q;
	assign result.result_kind    = kind_q;
	assign result.out_handle     = out_handle_q;
	assign result.frame_lag      = lag_out_q;
	assign result.occupancy      = occ_q;
	assign result.high_water     = hw_q;
	assign result.overflow_total = ovf_out_q;
	assign result.worst_wait     = worst_q;
	assign result.alloc_request  = alloc_out_q;
	assign result.last_of_run    = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/frame_pool_fifo_with_stats.sv =====
// push, refused push and empty pop are emitted from the EXEC state (an empty pop after a
//   release from FINISH); a pop or a release of the head passes through LOAD and TAKE first,
//   and every emission waits for a free output register; the block takes no new item until
//   the last one is through, and each head removal reads the stores
// reset: pointers, occupancy, statistics, time and config return to defaults at once;
//   the handle and stamp stores are not cleared, so items are accepted right after reset
// ----------------------------------------------------------------------------
// frame_pool_fifo_with_stats
// Bounded fifo of frame handles with per-entry time stamps, queue statistics
// and optional pool adjust.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pool_fifo_with_stats #(
	parameter int DEPTH       = fpfs_pkg::DEPTH_DEF,
	parameter int MARGIN      = fpfs_pkg::MARGIN_DEF,
	parameter int HANDLE_BITS = fpfs_pkg::HANDLE_BITS_DEF,
	parameter int TIME_BITS   = fpfs_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fpfs_item_if.sink                          item,
	fpfs_result_if.source                      result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fpfs_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [fpfs_pkg::CFG_DW-1:0]   pwdata,
	output logic      [fpfs_pkg::CFG_DW-1:0]   prdata,
	output logic                               pready
);

	fpfs_pkg::cfg_t        cfg;
	fpfs_pkg::ctl_cmd_t    cmd;
	fpfs_pkg::dp_status_t  status;
	logic                  item_ready;

	assign item.ready = item_ready;

	fpfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpfs_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	fpfs_dp #(
		.DEPTH       (DEPTH),
		.MARGIN      (MARGIN),
		.HANDLE_BITS (HANDLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.item_mode   (item.mode),
		.item_handle (item.frame_handle),
		.result      (result)
	);

	// a result is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result loaded while output register busy");

	// the head is never removed from an empty queue
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> status.count_nz)
		else $error("head taken from empty queue");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item accepted while previous item in progress");

	// an empty pop carries no handle and no lag
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.result_kind == fpfs_pkg::KIND_EMPTY)) |->
		((result.out_handle == '0) && (result.frame_lag == '0)))
		else $error("empty pop result with nonzero payload");

endmodule

`default_nettype wire
